### src/assert_macros.svh
// Assertion shorthands for the phase-space shift advection RTL.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/psa_pkg.sv
// Shared constants, request codes and types for the phase-space shift advection block.
// No dependencies; imported by psa_shift and phase_space_shift_advection.
`default_nettype none

package psa_pkg;

	// Grid size (power of two: index wrap is a bit mask)
	localparam int POS_CELLS = 64;
	localparam int VEL_CELLS = 64;
	localparam int POS_W     = $clog2(POS_CELLS);
	localparam int VEL_W     = $clog2(VEL_CELLS);
	localparam int ADDR_W    = POS_W + VEL_W;
	localparam int DEPTH     = POS_CELLS * VEL_CELLS;

	// Field widths
	localparam int CELL_W = 32;
	localparam int LOST_W = 48;
	localparam int CFG_W  = 32;

	// Request codes
	localparam logic [1:0] REQ_POS_SHIFT = 2'd0;
	localparam logic [1:0] REQ_VEL_SHIFT = 2'd1;
	localparam logic [1:0] REQ_READ_CELL = 2'd2;
	localparam logic [1:0] REQ_READ_LOST = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_POS_BASE = 2'd0;
	localparam logic [1:0] CFG_POS_STEP = 2'd1;
	localparam logic [1:0] CFG_VEL_GAIN = 2'd2;

	// Destination of one item
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [VEL_W-1:0] vel;
		logic             left;
	} dest_t;

endpackage

`default_nettype wire

### src/psa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module psa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/psa_shift.sv
// Shift unit: registered multiplies, then truncation toward zero and destination select.
// Depends on psa_pkg.
`default_nettype none

module psa_shift (
	input  wire logic                          clk,
	input  wire logic                          mul_en,
	input  wire logic [1:0]                    req,
	input  wire logic [psa_pkg::POS_W-1:0]     pos,
	input  wire logic [psa_pkg::VEL_W-1:0]     vel,
	input  wire logic [psa_pkg::CFG_W-1:0]     accel,
	input  wire logic [psa_pkg::CFG_W-1:0]     base,
	input  wire logic [psa_pkg::CFG_W-1:0]     step,
	input  wire logic [psa_pkg::CFG_W-1:0]     gain,
	output psa_pkg::dest_t                     dest
);

	import psa_pkg::*;

	localparam int PP_W = CFG_W + VEL_W + 1;   // base + step*vel, Q23.16
	localparam int VP_W = 2 * CFG_W;           // accel*gain, Q32.32
	localparam int NV_W = CFG_W + 2;           // vel + integer shift

	logic signed [PP_W-1:0] step_x, vel_x, base_x;
	logic signed [PP_W-1:0] pprod_s1;
	logic signed [CFG_W-1:0] accel_x, gain_x;
	logic signed [VP_W-1:0] vprod_s1;
	logic [POS_W-1:0] pround, dpos;
	logic [CFG_W-1:0] vint;
	logic signed [NV_W-1:0] nv;
	logic vleft;

	assign step_x  = {{(PP_W-CFG_W){step[CFG_W-1]}}, step};
	assign base_x  = {{(PP_W-CFG_W){base[CFG_W-1]}}, base};
	assign vel_x   = {{(PP_W-VEL_W){1'b0}}, vel};
	assign accel_x = accel;
	assign gain_x  = gain;

	// Multiply stage
	always_ff @(posedge clk) begin
		if (mul_en) begin
			pprod_s1 <= base_x + step_x * vel_x;
			vprod_s1 <= VP_W'(accel_x) * VP_W'(gain_x);
		end
	end

	// Position: floor plus one when negative with a fraction gives truncation toward zero;
	// only the low bits survive the wrap.
	assign pround = {{(POS_W-1){1'b0}}, pprod_s1[PP_W-1] & (|pprod_s1[15:0])};
	assign dpos   = pos + pprod_s1[16 +: POS_W] + pround;

	// Velocity: integer part of the Q32.32 product, truncated toward zero
	assign vint  = vprod_s1[VP_W-1 -: CFG_W]
		+ {{(CFG_W-1){1'b0}}, vprod_s1[VP_W-1] & (|vprod_s1[CFG_W-1:0])};
	assign nv    = {{(NV_W-VEL_W){1'b0}}, vel} + {{(NV_W-CFG_W){vint[CFG_W-1]}}, vint};
	assign vleft = nv[NV_W-1] | (|nv[NV_W-2:VEL_W]);

	// Select destination by request
	always_comb begin
		dest = '0;
		case (req)
			REQ_POS_SHIFT: begin
				dest.pos = dpos;
				dest.vel = vel;
			end
			REQ_VEL_SHIFT: begin
				dest.pos  = pos;
				dest.vel  = vleft ? '0 : nv[VEL_W-1:0];
				dest.left = vleft;
			end
			REQ_READ_CELL: begin
				dest.pos = pos;
				dest.vel = vel;
			end
			default: begin
				dest = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### src/phase_space_shift_advection.sv
// Phase-space shift advection: integer-shift scatter-accumulate into a 64x64 cell store.
// Usage:
//   Input stream s_*: one word per request; s_tuser carries the request kind, s_tdata the
//   source cell. Output stream m_*: exactly one result word per request, in order.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write the three Q16.16 shift registers;
//   write only while no request is in flight.
// Sequence: an accepted request passes through the multiply, address and memory read and
//   read-modify-write states before its result is registered. A new request is not taken
//   until the current one finishes its read-modify-write through the single store memory;
//   s_tready rises again in the cycle the result is registered.
// Reset: arst_n clears the control and configuration registers and lost mass, then a
//   clearing pass writes zero to all 4096 store entries, one per cycle; s_tready stays low until it ends.
// Stall: a result waits in the output register while m_tready is low; the next request
//   may still be accepted and proceeds up to its write-back, where it holds until the
//   output register frees.
// Depends on psa_pkg, psa_ram, psa_shift and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module phase_space_shift_advection (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // pos_index[5:0], vel_index[11:6],
	                                    // cell_value[43:12], row_accel[75:44], zero[79:76]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // dest_pos[5:0], dest_vel[11:6], left_grid[12],
	                                    // read_value[60:13], saturated[61], zero[63:62]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	import psa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADDR = 2'd2;
	localparam logic [1:0] ST_RD   = 2'd3;

	logic [1:0]        state_q;
	logic [ADDR_W:0]   clr_cnt_q;
	logic              clr_busy;
	logic [CFG_W-1:0]  base_q, step_q, gain_q;
	logic [1:0]        req_q;
	logic [POS_W-1:0]  pos_q;
	logic [VEL_W-1:0]  vel_q;
	logic [CELL_W-1:0] val_q;
	logic [CFG_W-1:0]  accel_q;
	dest_t             dest, dest_q;
	logic [LOST_W-1:0] lost_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;

	logic              accept, finish, acc_cell, lost_acc;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic [CELL_W:0]   cell_sum;
	logic              cell_sat;
	logic [CELL_W-1:0] cell_new;
	logic [LOST_W:0]   lost_sum;
	logic              lost_sat;
	logic [LOST_W-1:0] read_value;
	logic              sat;

	assign clr_busy = ~clr_cnt_q[ADDR_W];
	assign s_tready = (state_q == ST_IDLE) & ~clr_busy;
	assign accept   = s_tvalid & s_tready;
	assign finish   = (state_q == ST_RD) & (~m_tvalid_q | m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			step_q <= '0;
			gain_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_POS_BASE: base_q <= cfg_wdata;
				CFG_POS_STEP: step_q <= cfg_wdata;
				CFG_VEL_GAIN: gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clr_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_RD;
				ST_RD:   if (finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= s_tuser;
			pos_q   <= s_tdata[POS_W-1:0];
			vel_q   <= s_tdata[6 +: VEL_W];
			val_q   <= s_tdata[43:12];
			accel_q <= s_tdata[75:44];
		end
	end

	psa_shift u_shift (
		.clk    (clk),
		.mul_en (state_q == ST_MUL),
		.req    (req_q),
		.pos    (pos_q),
		.vel    (vel_q),
		.accel  (accel_q),
		.base   (base_q),
		.step   (step_q),
		.gain   (gain_q),
		.dest   (dest)
	);

	// Latch the destination while the store read is issued
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			dest_q <= dest;
		end
	end

	// Saturating sums
	assign cell_sum = {1'b0, ram_rdata} + {1'b0, val_q};
	assign cell_sat = cell_sum[CELL_W];
	assign cell_new = cell_sat ? {CELL_W{1'b1}} : cell_sum[CELL_W-1:0];
	assign lost_sum = {1'b0, lost_q} + {{(LOST_W-CELL_W+1){1'b0}}, val_q};
	assign lost_sat = lost_sum[LOST_W];

	assign acc_cell = (req_q == REQ_POS_SHIFT) | ((req_q == REQ_VEL_SHIFT) & ~dest_q.left);
	assign lost_acc = (req_q == REQ_VEL_SHIFT) & dest_q.left;

	// Store port: clear sweep, else write-back of the finished item (zero for a cell read)
	assign ram_re = (state_q == ST_ADDR);
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {dest_q.pos, dest_q.vel};
		ram_wdata = '0;
		if (clr_busy) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q[ADDR_W-1:0];
		end else if (finish & (acc_cell | (req_q == REQ_READ_CELL))) begin
			ram_we    = 1'b1;
			ram_wdata = (req_q == REQ_READ_CELL) ? '0 : cell_new;
		end
	end

	psa_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr ({dest.pos, dest.vel}),
		.rdata (ram_rdata)
	);

	// Lost mass: accumulate or read and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q <= '0;
		end else if (finish & lost_acc) begin
			lost_q <= lost_sat ? {LOST_W{1'b1}} : lost_sum[LOST_W-1:0];
		end else if (finish & (req_q == REQ_READ_LOST)) begin
			lost_q <= '0;
		end
	end

	// Result fields
	always_comb begin
		case (req_q)
			REQ_READ_CELL: read_value = {{(LOST_W-CELL_W){1'b0}}, ram_rdata};
			REQ_READ_LOST: read_value = lost_q;
			default:       read_value = '0;
		endcase
	end
	assign sat = (acc_cell & cell_sat) | (lost_acc & lost_sat);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= {2'b00, sat, read_value, dest_q.left, dest_q.vel, dest_q.pos};
		end
	end

	`PSA_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !s_tready, "word accepted during clear")
	`PSA_ASSERT_NOW(a_we_only_rd_or_clr, ram_we, (state_q == ST_RD) || clr_busy, "stray store write")
	`PSA_ASSERT_NEXT(a_accept_to_mul, accept, state_q == ST_MUL, "accepted word not multiplied")
	`PSA_ASSERT_NEXT(a_lost_cleared, finish && (req_q == REQ_READ_LOST), lost_q == '0, "lost mass kept")

endmodule

`default_nettype wire
